### rtl/id3t_pkg.sv
// Shared types and constants for the ID3 text frame to UTF-8 transcoder.
package id3t_pkg;

    // Default zero-run count limit; the run counter is 16 bits wide.
    localparam int unsigned ZERO_COUNT_MAX_DEF = 65535;
    localparam int unsigned ZERO_CNT_W         = 16;

    // Encoding byte values at the head of a frame.
    localparam logic [7:0] ENC_BYTE_LATIN1  = 8'h00;
    localparam logic [7:0] ENC_BYTE_UTF16   = 8'h01;
    localparam logic [7:0] ENC_BYTE_UTF16BE = 8'h02;
    localparam logic [7:0] ENC_BYTE_UTF8    = 8'h03;

    // Byte-order marks as read high byte first.
    localparam logic [15:0] BOM_LE = 16'hFFFE;
    localparam logic [15:0] BOM_BE = 16'hFEFF;

    // UTF-8 range limits.
    localparam logic [15:0] UTF8_LIM1 = 16'h0080;
    localparam logic [15:0] UTF8_LIM2 = 16'h0800;

    typedef enum logic [1:0] {
        ENC_PASS     = 2'd0,
        ENC_UTF16    = 2'd1,
        ENC_UTF16_BE = 2'd2
    } t_enc;

    // Result group produced by one input byte: up to three output bytes.
    typedef struct packed {
        logic [1:0]            cnt;
        logic [2:0][7:0]       bytes;
        logic [ZERO_CNT_W-1:0] zeros;
    } t_group;

endpackage

### rtl/id3t_decode.sv
// Per-byte frame decoder: encoding state, zero-run count and UTF-16 to UTF-8 mapping.
module id3t_decode #(
    parameter int unsigned ZERO_COUNT_MAX = id3t_pkg::ZERO_COUNT_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data,
    input  logic             i_fe,
    output id3t_pkg::t_group o_grp
);
    import id3t_pkg::*;

    localparam logic [ZERO_CNT_W-1:0] ZERO_CAP =
        (ZERO_COUNT_MAX < 65535) ? ZERO_CNT_W'(ZERO_COUNT_MAX) : {ZERO_CNT_W{1'b1}};

    logic                  r_expect, n_expect;
    t_enc                  r_kind, n_kind;
    logic                  r_invalid, n_invalid;
    logic                  r_big, n_big;
    logic                  r_first, n_first;
    logic                  r_half, n_half;
    logic [7:0]            r_held, n_held;
    logic                  r_stop, n_stop;
    logic [ZERO_CNT_W-1:0] r_zeros, n_zeros;

    logic [15:0] mark;
    logic [15:0] cp;
    logic        skip;

    always_comb begin
        n_expect  = r_expect;
        n_kind    = r_kind;
        n_invalid = r_invalid;
        n_big     = r_big;
        n_first   = r_first;
        n_half    = r_half;
        n_held    = r_held;
        n_stop    = r_stop;
        n_zeros   = r_zeros;
        o_grp     = '0;
        mark      = {r_held, i_data};
        cp        = r_big ? {r_held, i_data} : {i_data, r_held};
        skip      = 1'b0;

        if (r_expect) begin
            n_expect  = 1'b0;
            n_first   = 1'b1;
            n_half    = 1'b0;
            n_stop    = 1'b0;
            n_zeros   = '0;
            n_invalid = 1'b0;
            n_big     = 1'b0;
            n_kind    = ENC_PASS;
            case (i_data)
                ENC_BYTE_LATIN1, ENC_BYTE_UTF8: n_kind = ENC_PASS;
                ENC_BYTE_UTF16:                 n_kind = ENC_UTF16;
                ENC_BYTE_UTF16BE: begin
                    n_kind = ENC_UTF16_BE;
                    n_big  = 1'b1;
                end
                default:                        n_invalid = 1'b1;
            endcase
        end else if (r_invalid || r_stop) begin
            // rest of frame ignored
        end else if (r_kind == ENC_PASS) begin
            if (i_data == 8'd0) begin
                if (r_zeros < ZERO_CAP) n_zeros = r_zeros + 1'b1;
            end else begin
                o_grp.cnt      = 2'd1;
                o_grp.bytes[0] = i_data;
                o_grp.zeros    = r_zeros;
                n_zeros        = '0;
            end
        end else if (!r_half) begin
            n_held = i_data;
            n_half = 1'b1;
        end else begin
            n_half = 1'b0;
            if (r_first) begin
                n_first = 1'b0;
                if (r_kind == ENC_UTF16) begin
                    if (mark == BOM_LE) begin
                        n_big = 1'b0;
                        skip  = 1'b1;
                    end else if (mark == BOM_BE) begin
                        n_big = 1'b1;
                        skip  = 1'b1;
                    end
                end
            end
            if (!skip) begin
                if (cp == 16'd0) begin
                    n_stop = 1'b1;
                end else if (cp < UTF8_LIM1) begin
                    o_grp.cnt      = 2'd1;
                    o_grp.bytes[0] = cp[7:0];
                end else if (cp < UTF8_LIM2) begin
                    o_grp.cnt      = 2'd2;
                    o_grp.bytes[0] = {3'b110, cp[10:6]};
                    o_grp.bytes[1] = {2'b10, cp[5:0]};
                end else begin
                    o_grp.cnt      = 2'd3;
                    o_grp.bytes[0] = {4'b1110, cp[15:12]};
                    o_grp.bytes[1] = {2'b10, cp[11:6]};
                    o_grp.bytes[2] = {2'b10, cp[5:0]};
                end
            end
        end

        if (i_fe) begin
            n_expect  = 1'b1;
            n_kind    = ENC_PASS;
            n_invalid = 1'b0;
            n_big     = 1'b0;
            n_first   = 1'b1;
            n_half    = 1'b0;
            n_held    = '0;
            n_stop    = 1'b0;
            n_zeros   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect  <= 1'b1;
            r_kind    <= ENC_PASS;
            r_invalid <= 1'b0;
            r_big     <= 1'b0;
            r_first   <= 1'b1;
            r_half    <= 1'b0;
            r_held    <= '0;
            r_stop    <= 1'b0;
            r_zeros   <= '0;
        end else if (i_step) begin
            r_expect  <= n_expect;
            r_kind    <= n_kind;
            r_invalid <= n_invalid;
            r_big     <= n_big;
            r_first   <= n_first;
            r_half    <= n_half;
            r_held    <= n_held;
            r_stop    <= n_stop;
            r_zeros   <= n_zeros;
        end
    end

endmodule

### rtl/id3t_serial.sv
// Result register: holds one result group and hands its bytes out one per transaction.
module id3t_serial (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  id3t_pkg::t_group                    i_grp,
    output logic                                o_free,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [7:0]                          o_text_byte,
    output logic [id3t_pkg::ZERO_CNT_W-1:0]     o_zeros_before,
    output logic                                o_run_last
);
    import id3t_pkg::*;

    logic       r_valid;
    logic [1:0] r_idx;
    t_group     r_grp;
    logic       last;

    assign last           = (r_idx == (r_grp.cnt - 2'd1));
    assign o_valid        = r_valid;
    assign o_run_last     = last;
    assign o_text_byte    = r_grp.bytes[r_idx];
    assign o_zeros_before = r_grp.zeros;
    assign o_free         = !r_valid || (i_ready && last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load && (i_grp.cnt != 2'd0)) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_ready) begin
            if (last) r_valid <= 1'b0;
            else      r_idx   <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && (i_grp.cnt != 2'd0)) r_grp <= i_grp;
    end

endmodule

### rtl/id3_text_frame_to_utf8_core.sv
// Top level of the ID3 text frame to UTF-8 transcoder.
// Data path: a byte accepted into the input register moves through the decoder into the
//   result register once the result register is free.
// Throughput: one input byte per cycle while each byte yields at most one result and the
//   output is ready; a multi-byte result keeps the result register until fully taken.
// Reset: synchronous active-low; clears the input stage, result register and frame state
//   (awaiting an encoding byte). No clearing pass.
module id3_text_frame_to_utf8_core #(
    parameter int unsigned ZERO_COUNT_MAX = id3t_pkg::ZERO_COUNT_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_frame_end,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_text_byte,
    output logic [id3t_pkg::ZERO_CNT_W-1:0] o_zeros_before,
    output logic                            o_run_last
);
    import id3t_pkg::*;

    // Input register: one accepted byte waiting for the decoder.
    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_fe;

    t_group     grp;
    logic       free;     // result register can take a new group this cycle
    logic       advance;  // input register moves through the decoder

    assign advance    = r_in_valid && free;
    // A new byte is taken whenever the input register is empty or emptying.
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_data_byte;
            r_in_fe   <= i_frame_end;
        end
    end

    // Decoder: frame state advances once per byte as it leaves the input register.
    id3t_decode #(
        .ZERO_COUNT_MAX(ZERO_COUNT_MAX)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_data  (r_in_data),
        .i_fe    (r_in_fe),
        .o_grp   (grp)
    );

    // Result register and byte serializer; bytes that yield nothing leave no group.
    id3t_serial u_serial (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance),
        .i_grp          (grp),
        .o_free         (free),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_text_byte    (o_text_byte),
        .o_zeros_before (o_zeros_before),
        .o_run_last     (o_run_last)
    );

    // A zero-run count only rides on a single pass-through byte.
    a_zeros_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_zeros_before != '0)) |-> o_run_last)
        else $error("zero count on a multi-byte result");

    // Leading and middle bytes of a multi-byte sequence have the top bit set.
    a_lead_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_run_last) |-> o_text_byte[7])
        else $error("non-final UTF-8 byte without top bit");

    // A group is never cut short: after a non-final byte is taken, another follows.
    a_group_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_run_last) |=> o_out_valid)
        else $error("result group ended early");

    // The input stage stays blocked while its byte waits for the result register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !free) |-> !o_in_ready)
        else $error("input accepted while stage full");

endmodule
